// ----- hdl/ssam_pkg.sv -----
`timescale 1ns / 1ps

package ssam_pkg;

  localparam int POS_W = 10;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  localparam logic RES_MATCH = 1'b0;
  localparam logic RES_END   = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] pattern_index;
    logic       text_last;
  } ssam_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] match_position;
    logic             none_found;
    logic             last;
  } ssam_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EMIT_MATCH,
    ST_EMIT_END
  } ssam_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pat_wr;
    logic text_acc;
    logic shift;
    logic cmp_run;
    logic load_match;
    logic load_end;
  } ssam_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_ok;
    logic cmp_needed;
    logic cmp_done;
    logic cmp_hit;
    logic tlast;
    logic slot_free;
  } ssam_status_t;

endpackage

// ----- hdl/ssam_dp.sv -----
`timescale 1ns / 1ps

module ssam_dp #(
  parameter int PAT_MAX  = 128,
  parameter int TEXT_MAX = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  ssam_pkg::ssam_in_t   in_data,
  input  ssam_pkg::ssam_cmd_t  cmd,
  output ssam_pkg::ssam_status_t st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssam_pkg::ssam_out_t  out_data
);

  localparam int AW    = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int MW    = $clog2(PAT_MAX + 1);
  localparam int CW    = (MW > 8) ? MW : 8;
  localparam int CNT_W = $clog2(TEXT_MAX + 1);
  localparam int XW    = ((CNT_W > MW) ? CNT_W : MW) + 1;
  localparam int SW    = $clog2(2 * PAT_MAX + 1);

  logic [7:0]       len_r;
  logic [AW-1:0]    head_r;
  logic [AW-1:0]    wa_r;
  logic [MW-1:0]    j_r;
  logic [CNT_W-1:0] count_r;
  logic             any_r;
  logic             rv_r;
  logic             miss_r;
  logic             tlast_r;
  logic [7:0]       win_q_r;
  logic [7:0]       pat_q_r;
  logic             out_valid_r;
  ssam_pkg::ssam_out_t out_data_r;

  logic [7:0] pat_mem [PAT_MAX];
  logic [7:0] win_mem [PAT_MAX];

  logic [CW-1:0] len_ext;
  logic [CW-1:0] m_full;
  logic [MW-1:0] m;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] wa_inc;
  logic [SW-1:0] s_sum;
  logic [AW-1:0] start;
  logic          issue;
  logic          idx_ok;
  logic [XW-1:0] pos_full;
  logic          slot_free;

  // Effective length is the register clipped to the store depth.
  assign len_ext = CW'(len_r);
  assign m_full  = (len_ext > CW'(PAT_MAX)) ? CW'(PAT_MAX) : len_ext;
  assign m       = MW'(m_full);

  assign head_inc = (head_r == AW'(PAT_MAX - 1)) ? '0 : head_r + AW'(1);
  assign wa_inc   = (wa_r == AW'(PAT_MAX - 1)) ? '0 : wa_r + AW'(1);

  // Oldest byte of the compared span sits m-1 places behind the newest one.
  assign s_sum = SW'(head_inc) + SW'(PAT_MAX) + SW'(1) - SW'(m);
  assign start = (s_sum >= SW'(PAT_MAX)) ? AW'(s_sum - SW'(PAT_MAX)) : AW'(s_sum);

  assign issue    = cmd.cmp_run && (j_r < m);
  assign idx_ok   = (32'(in_data.pattern_index) < PAT_MAX);
  assign pos_full = XW'(count_r) - XW'(m);
  assign slot_free = !out_valid_r || out_ready;

  assign st.shift_ok   = (count_r < CNT_W'(TEXT_MAX));
  assign st.cmp_needed = (m != '0) && ((XW'(count_r) + XW'(1)) >= XW'(m));
  assign st.cmp_done   = (j_r >= m) && !rv_r;
  assign st.cmp_hit    = !miss_r;
  assign st.tlast      = tlast_r;
  assign st.slot_free  = slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.pat_wr && idx_ok) begin
      pat_mem[AW'(in_data.pattern_index)] <= in_data.data_byte;
    end
    if (issue) begin
      pat_q_r <= pat_mem[j_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win_mem[head_inc] <= in_data.data_byte;
    end
    if (issue) begin
      win_q_r <= win_mem[wa_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_acc) begin
      tlast_r <= in_data.text_last;
    end
    if (cmd.load_match) begin
      out_data_r.result_kind    <= ssam_pkg::RES_MATCH;
      out_data_r.match_position <= ssam_pkg::POS_W'(pos_full);
      out_data_r.none_found     <= 1'b0;
      out_data_r.last           <= !tlast_r;
    end else if (cmd.load_end) begin
      out_data_r.result_kind    <= ssam_pkg::RES_END;
      out_data_r.match_position <= '0;
      out_data_r.none_found     <= !any_r;
      out_data_r.last           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      head_r      <= '0;
      wa_r        <= '0;
      j_r         <= '0;
      count_r     <= '0;
      any_r       <= 1'b0;
      rv_r        <= 1'b0;
      miss_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      rv_r <= issue;
      if (cmd.shift) begin
        head_r  <= head_inc;
        wa_r    <= start;
        j_r     <= '0;
        miss_r  <= 1'b0;
        count_r <= count_r + CNT_W'(1);
      end else begin
        if (issue) begin
          wa_r <= wa_inc;
          j_r  <= j_r + MW'(1);
        end
        if (rv_r && (win_q_r != pat_q_r)) begin
          miss_r <= 1'b1;
        end
        if (cmd.load_end) begin
          count_r <= '0;
        end
      end
      if (cmd.load_match) begin
        any_r <= 1'b1;
      end else if (cmd.load_end) begin
        any_r <= 1'b0;
      end
      if (cmd.load_match || cmd.load_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/ssam_ctrl.sv -----
`timescale 1ns / 1ps

module ssam_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_kind,
  input  logic                   in_last,
  output logic                   in_ready,
  input  ssam_pkg::ssam_status_t st,
  output ssam_pkg::ssam_cmd_t    cmd
);

  ssam_pkg::ssam_state_t state_r;
  ssam_pkg::ssam_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssam_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssam_pkg::ST_IDLE: begin
        if (in_valid && (in_kind == ssam_pkg::KIND_TEXT)) begin
          if (st.shift_ok && st.cmp_needed) begin
            state_nxt = ssam_pkg::ST_CMP;
          end else if (in_last) begin
            state_nxt = ssam_pkg::ST_EMIT_END;
          end
        end
      end
      ssam_pkg::ST_CMP: begin
        if (st.cmp_done) begin
          if (st.cmp_hit) begin
            state_nxt = ssam_pkg::ST_EMIT_MATCH;
          end else if (st.tlast) begin
            state_nxt = ssam_pkg::ST_EMIT_END;
          end else begin
            state_nxt = ssam_pkg::ST_IDLE;
          end
        end
      end
      ssam_pkg::ST_EMIT_MATCH: begin
        if (st.slot_free) begin
          state_nxt = st.tlast ? ssam_pkg::ST_EMIT_END : ssam_pkg::ST_IDLE;
        end
      end
      ssam_pkg::ST_EMIT_END: begin
        if (st.slot_free) begin
          state_nxt = ssam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssam_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ssam_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == ssam_pkg::KIND_PATTERN) begin
            cmd.pat_wr = 1'b1;
          end else begin
            cmd.text_acc = 1'b1;
            cmd.shift    = st.shift_ok;
          end
        end
      end
      ssam_pkg::ST_CMP: begin
        cmd.cmp_run = 1'b1;
      end
      ssam_pkg::ST_EMIT_MATCH: begin
        cmd.load_match = st.slot_free;
      end
      ssam_pkg::ST_EMIT_END: begin
        cmd.load_end = st.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A result is only loaded into an empty or draining output slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_match || cmd.load_end) |-> st.slot_free)
    else $error("result loaded into a full output slot");

  // A match result is only reached from a compare pass that found no mismatch.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssam_pkg::ST_CMP && state_nxt == ssam_pkg::ST_EMIT_MATCH)
      |-> (st.cmp_done && st.cmp_hit))
    else $error("match reported without a finished, clean compare");

  // A new text byte never starts while a compare pass is still running.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> !$past(cmd.cmp_run) || $past(st.cmp_done))
    else $error("window shifted during a compare pass");

  // After a final byte is taken with no compare, the controller goes straight to the end result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.text_acc && in_last && !(st.shift_ok && st.cmp_needed))
      |=> (state_r == ssam_pkg::ST_EMIT_END))
    else $error("end of text not reported");

endmodule

// ----- hdl/substring_search_all_matches_core.sv -----
`timescale 1ns / 1ps
// Streaming substring search that reports every start position, overlaps included.
// Input channel (in_valid/in_ready/in_data): a request with kind 0 writes one pattern
// byte at pattern_index; a request with kind 1 delivers the next text byte, and
// text_last marks the final byte of a text. Configuration channel (cfg_valid/cfg_ready/
// cfg_data) sets the pattern length and is always ready; write it only while idle.
// Result channel (out_valid/out_ready/out_data): a match result carries the start
// position; the final text byte also yields an end result that flags a text without
// any match. A text byte produces zero, one or two results.
// A text byte that can complete a match (at least m bytes of the current text seen,
// m = effective pattern length) runs a compare pass that reads the pattern store and
// the text window one byte a cycle; the reads are registered, so the last compare
// finishes after the last read. A byte that cannot complete a match runs no compare
// pass; a final byte then still yields the end result. Each result is emitted in turn.
// The result sits in an output register, so the next request is accepted while that
// result waits; a stalled receiver only holds the block once a second result is due.
// Reset clears the length, the text position and the match flag; the pattern store
// holds nothing meaningful until written. There is no clearing pass.

module substring_search_all_matches_core #(
  parameter int PAT_MAX  = 128,
  parameter int TEXT_MAX = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssam_pkg::ssam_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssam_pkg::ssam_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  ssam_pkg::ssam_cmd_t    cmd;
  ssam_pkg::ssam_status_t st;

  // The length register has no hazard against the datapath while idle, so the
  // configuration channel never stalls.
  assign cfg_ready = 1'b1;

  // The controller sequences accepting requests, the compare pass and the results.
  ssam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_last  (in_data.text_last),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the pattern store, the circular text window, the position
  // counter, the compare unit and the output register.
  ssam_dp #(
    .PAT_MAX  (PAT_MAX),
    .TEXT_MAX (TEXT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
